### sv/srdenc_pkg.sv
// ----------------------------------------------------------------------------
// srdenc_pkg
// Shared types, codes and helper functions of the single-end read
// descriptor encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package srdenc_pkg;

  localparam int POS_WIDTH_DEF = 40;
  localparam int LEN_WIDTH_DEF = 16;

  localparam int ACT_W    = 3;
  localparam int LEN_IN_W = 16;
  localparam int CNT_W    = 16;
  localparam int CHAR_W   = 8;
  localparam int SID_W    = 4;
  localparam int VAL_W    = 40;
  localparam int MAX_RES  = 5;
  localparam int RCNT_W   = $clog2(MAX_RES + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_START     = 3'd0,
    ACT_ALIGNED   = 3'd1,
    ACT_MISMATCH  = 3'd2,
    ACT_UNALIGNED = 3'd3,
    ACT_BASE      = 3'd4
  } action_t;

  // descriptor stream ids
  localparam logic [SID_W-1:0] S_RLEN    = 4'd0;
  localparam logic [SID_W-1:0] S_RTYPE   = 4'd1;
  localparam logic [SID_W-1:0] S_UREADS  = 4'd2;
  localparam logic [SID_W-1:0] S_RCOMP   = 4'd3;
  localparam logic [SID_W-1:0] S_POS     = 4'd4;
  localparam logic [SID_W-1:0] S_MMTERM  = 4'd5;
  localparam logic [SID_W-1:0] S_MMPOS   = 4'd6;
  localparam logic [SID_W-1:0] S_MMTYPE  = 4'd7;
  localparam logic [SID_W-1:0] S_MMSUBST = 4'd8;

  // read type codes
  localparam logic [VAL_W-1:0] RTYPE_PERFECT    = 40'd1;
  localparam logic [VAL_W-1:0] RTYPE_MISMATCHED = 40'd3;
  localparam logic [VAL_W-1:0] RTYPE_UNALIGNED  = 40'd5;

  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T = 8'h54;
  localparam logic [CHAR_W-1:0] CH_N = 8'h4e;
  localparam logic [CHAR_W-1:0] CH_D = 8'h64;
  localparam logic [CHAR_W-1:0] CH_R = 8'h72;

  typedef struct packed {
    logic [SID_W-1:0] sid;
    logic [VAL_W-1:0] val;
    logic             bad;
  } res_t;

  typedef struct packed {
    logic       bad;
    logic [2:0] code;
  } nuc_t;

  function automatic nuc_t nuc_lookup(input logic [CHAR_W-1:0] c);
    nuc_t r;
    r.bad  = 1'b0;
    r.code = 3'd0;
    case (c)
      CH_A:    r.code = 3'd0;
      CH_C:    r.code = 3'd1;
      CH_G:    r.code = 3'd2;
      CH_T:    r.code = 3'd3;
      CH_N:    r.code = 3'd4;
      default: r.bad  = 1'b1;
    endcase
    return r;
  endfunction

  function automatic res_t mk_res(input logic [SID_W-1:0] sid, input logic [VAL_W-1:0] val,
                                  input logic bad);
    res_t r;
    r.sid = sid;
    r.val = val;
    r.bad = bad;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/single_end_read_descriptor_encoder_core.sv
// ----------------------------------------------------------------------------
// single_end_read_descriptor_encoder_core
// Turns a request stream of block, read, mismatch and base items into
// tagged descriptor symbols.
// ----------------------------------------------------------------------------
// flow: a request is registered in the input stage and moves into the result
//   buffer once the buffer is free; entry 0 of the buffer is the output
// throughput: one symbol per cycle on the output while out_ready is high;
//   the input stage can take the next request while the single result buffer
//   drains one entry per cycle
// reset: synchronous, clears the input stage, the result buffer and all state
`default_nettype none

module single_end_read_descriptor_encoder_core #(
  parameter int POS_WIDTH = srdenc_pkg::POS_WIDTH_DEF,
  parameter int LEN_WIDTH = srdenc_pkg::LEN_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [srdenc_pkg::ACT_W-1:0]       action,
  input  wire logic [POS_WIDTH-1:0]               ref_start,
  input  wire logic [POS_WIDTH-1:0]               ref_end,
  input  wire logic [srdenc_pkg::LEN_IN_W-1:0]    read_len,
  input  wire logic [POS_WIDTH-1:0]               read_position,
  input  wire logic [srdenc_pkg::CHAR_W-1:0]      strand_char,
  input  wire logic [srdenc_pkg::CNT_W-1:0]       mismatch_count,
  input  wire logic [srdenc_pkg::CNT_W-1:0]       mismatch_offset,
  input  wire logic [srdenc_pkg::CHAR_W-1:0]      base_char,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [srdenc_pkg::SID_W-1:0]            stream_id,
  output logic [srdenc_pkg::VAL_W-1:0]            symbol_value,
  output logic                                    bad_symbol,
  output logic                                    last
);

  localparam int VW     = srdenc_pkg::VAL_W;
  localparam int WIDE_W = (POS_WIDTH > VW) ? POS_WIDTH : VW;
  localparam int NRES   = srdenc_pkg::MAX_RES;

  function automatic logic [VW-1:0] pos_val(input logic [POS_WIDTH-1:0] p);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(p);
    return w[VW-1:0];
  endfunction

  // input stage
  logic                                 s1_valid;
  logic [srdenc_pkg::ACT_W-1:0]         s1_action;
  logic [POS_WIDTH-1:0]                 s1_ref_start;
  logic [POS_WIDTH-1:0]                 s1_ref_end;
  logic [LEN_WIDTH-1:0]                 s1_len;
  logic [POS_WIDTH-1:0]                 s1_pos;
  logic [srdenc_pkg::CHAR_W-1:0]        s1_strand;
  logic [srdenc_pkg::CNT_W-1:0]         s1_mcount;
  logic [srdenc_pkg::CNT_W-1:0]         s1_moff;
  logic [srdenc_pkg::CHAR_W-1:0]        s1_char;
  logic                                 s1_move;
  logic                                 in_accept;

  // encoder state
  logic [POS_WIDTH-1:0]                 prev_pos, prev_pos_next;
  logic [POS_WIDTH-1:0]                 ref_end_r, ref_end_next;
  logic                                 first_read, first_read_next;
  logic [LEN_WIDTH-1:0]                 bases_rem, bases_rem_next;
  logic                                 unaligned, unaligned_next;
  logic [srdenc_pkg::CNT_W-1:0]         mm_rem, mm_rem_next;
  logic                                 first_mm, first_mm_next;
  logic [LEN_WIDTH-1:0]                 held_len, held_len_next;

  // result buffer, entry 0 is shown on the output
  srdenc_pkg::res_t                     res [NRES];
  srdenc_pkg::res_t                     nres [NRES];
  logic [srdenc_pkg::RCNT_W-1:0]        cnt;
  logic [srdenc_pkg::RCNT_W-1:0]        ncnt;
  logic                                 buf_free;

  srdenc_pkg::nuc_t                     nuc;
  logic [LEN_WIDTH-1:0]                 len_m1;
  logic [LEN_WIDTH-1:0]                 held_m1;
  logic [srdenc_pkg::CNT_W-1:0]         moff_m1;

  assign buf_free  = (cnt == '0) ||
                     (cnt == srdenc_pkg::RCNT_W'(1) && out_ready);
  assign s1_move   = s1_valid && buf_free;
  assign in_ready  = !s1_valid || s1_move;
  assign in_accept = in_valid && in_ready;

  assign nuc     = srdenc_pkg::nuc_lookup(s1_char);
  assign len_m1  = s1_len - LEN_WIDTH'(1);
  assign held_m1 = held_len - LEN_WIDTH'(1);
  assign moff_m1 = s1_moff - srdenc_pkg::CNT_W'(1);

  always_comb begin
    prev_pos_next   = prev_pos;
    ref_end_next    = ref_end_r;
    first_read_next = first_read;
    bases_rem_next  = bases_rem;
    unaligned_next  = unaligned;
    mm_rem_next     = mm_rem;
    first_mm_next   = first_mm;
    held_len_next   = held_len;
    ncnt            = '0;
    for (int i = 0; i < NRES; i++) begin
      nres[i] = '0;
    end

    unique case (s1_action)
      srdenc_pkg::ACT_START: begin
        prev_pos_next   = '0;
        ref_end_next    = s1_ref_end;
        first_read_next = 1'b1;
        bases_rem_next  = '0;
        unaligned_next  = 1'b0;
        mm_rem_next     = '0;
        first_mm_next   = 1'b1;
        if (s1_ref_start != s1_ref_end) begin
          nres[0] = srdenc_pkg::mk_res(srdenc_pkg::S_RLEN,
                      pos_val(s1_ref_end - s1_ref_start - POS_WIDTH'(1)), 1'b0);
          nres[1] = srdenc_pkg::mk_res(srdenc_pkg::S_RTYPE,
                      srdenc_pkg::RTYPE_UNALIGNED, 1'b0);
          ncnt    = srdenc_pkg::RCNT_W'(2);
        end
      end
      srdenc_pkg::ACT_ALIGNED: begin
        bases_rem_next  = '0;
        unaligned_next  = 1'b0;
        nres[0] = srdenc_pkg::mk_res(srdenc_pkg::S_RLEN, VW'(len_m1), 1'b0);
        if (s1_strand == srdenc_pkg::CH_D) begin
          nres[1] = srdenc_pkg::mk_res(srdenc_pkg::S_RCOMP, VW'(0), 1'b0);
        end else if (s1_strand == srdenc_pkg::CH_R) begin
          nres[1] = srdenc_pkg::mk_res(srdenc_pkg::S_RCOMP, VW'(1), 1'b0);
        end else begin
          nres[1] = srdenc_pkg::mk_res(srdenc_pkg::S_RCOMP, VW'(0), 1'b1);
        end
        // first read of a block carries no delta
        nres[2] = srdenc_pkg::mk_res(srdenc_pkg::S_POS,
                    first_read ? VW'(0) : pos_val(s1_pos - prev_pos), 1'b0);
        nres[3] = srdenc_pkg::mk_res(srdenc_pkg::S_RTYPE,
                    (s1_mcount == '0) ? srdenc_pkg::RTYPE_PERFECT
                                      : srdenc_pkg::RTYPE_MISMATCHED, 1'b0);
        ncnt            = srdenc_pkg::RCNT_W'(4);
        prev_pos_next   = s1_pos;
        first_read_next = 1'b0;
        mm_rem_next     = s1_mcount;
        first_mm_next   = 1'b1;
        held_len_next   = s1_len;
      end
      srdenc_pkg::ACT_MISMATCH: begin
        if (mm_rem != '0) begin
          nres[0] = srdenc_pkg::mk_res(srdenc_pkg::S_MMTERM, VW'(0), 1'b0);
          // offsets after the first are stored one low
          nres[1] = srdenc_pkg::mk_res(srdenc_pkg::S_MMPOS,
                      first_mm ? VW'(s1_moff) : VW'(moff_m1), 1'b0);
          nres[2] = srdenc_pkg::mk_res(srdenc_pkg::S_MMTYPE, VW'(0), 1'b0);
          nres[3] = srdenc_pkg::mk_res(srdenc_pkg::S_MMSUBST, VW'(nuc.code), nuc.bad);
          ncnt    = srdenc_pkg::RCNT_W'(4);
          if (mm_rem == srdenc_pkg::CNT_W'(1)) begin
            nres[4] = srdenc_pkg::mk_res(srdenc_pkg::S_MMTERM, VW'(1), 1'b0);
            ncnt    = srdenc_pkg::RCNT_W'(5);
          end
          first_mm_next = 1'b0;
          mm_rem_next   = mm_rem - srdenc_pkg::CNT_W'(1);
        end
      end
      srdenc_pkg::ACT_UNALIGNED: begin
        mm_rem_next     = '0;
        first_read_next = 1'b0;
        nres[0] = srdenc_pkg::mk_res(srdenc_pkg::S_RTYPE, srdenc_pkg::RTYPE_UNALIGNED, 1'b0);
        nres[1] = srdenc_pkg::mk_res(srdenc_pkg::S_RLEN, VW'(len_m1), 1'b0);
        ncnt            = srdenc_pkg::RCNT_W'(2);
        held_len_next   = s1_len;
        bases_rem_next  = s1_len;
        unaligned_next  = (s1_len != '0);
      end
      srdenc_pkg::ACT_BASE: begin
        nres[0] = srdenc_pkg::mk_res(srdenc_pkg::S_UREADS, VW'(nuc.code), nuc.bad);
        ncnt    = srdenc_pkg::RCNT_W'(1);
        if (unaligned && bases_rem != '0) begin
          bases_rem_next = bases_rem - LEN_WIDTH'(1);
          // last base of an unaligned read: pseudo-alignment fields
          if (bases_rem == LEN_WIDTH'(1)) begin
            unaligned_next = 1'b0;
            nres[1] = srdenc_pkg::mk_res(srdenc_pkg::S_POS,
                        pos_val(ref_end_r - prev_pos), 1'b0);
            nres[2] = srdenc_pkg::mk_res(srdenc_pkg::S_RCOMP, VW'(0), 1'b0);
            nres[3] = srdenc_pkg::mk_res(srdenc_pkg::S_RLEN, VW'(held_m1), 1'b0);
            nres[4] = srdenc_pkg::mk_res(srdenc_pkg::S_RTYPE,
                        srdenc_pkg::RTYPE_PERFECT, 1'b0);
            ncnt          = srdenc_pkg::RCNT_W'(5);
            prev_pos_next = ref_end_r;
            ref_end_next  = ref_end_r + POS_WIDTH'(held_len);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action    <= action;
      s1_ref_start <= ref_start;
      s1_ref_end   <= ref_end;
      s1_len       <= read_len[LEN_WIDTH-1:0];
      s1_pos       <= read_position;
      s1_strand    <= strand_char;
      s1_mcount    <= mismatch_count;
      s1_moff      <= mismatch_offset;
      s1_char      <= base_char;
    end
    if (s1_move) begin
      for (int i = 0; i < NRES; i++) begin
        res[i] <= nres[i];
      end
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < NRES - 1; i++) begin
        res[i] <= res[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      cnt        <= '0;
      prev_pos   <= '0;
      ref_end_r  <= '0;
      first_read <= 1'b1;
      bases_rem  <= '0;
      unaligned  <= 1'b0;
      mm_rem     <= '0;
      first_mm   <= 1'b1;
      held_len   <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        cnt        <= ncnt;
        prev_pos   <= prev_pos_next;
        ref_end_r  <= ref_end_next;
        first_read <= first_read_next;
        bases_rem  <= bases_rem_next;
        unaligned  <= unaligned_next;
        mm_rem     <= mm_rem_next;
        first_mm   <= first_mm_next;
        held_len   <= held_len_next;
      end else if (out_valid && out_ready) begin
        cnt <= cnt - srdenc_pkg::RCNT_W'(1);
      end
    end
  end

  assign out_valid    = (cnt != '0);
  assign stream_id    = res[0].sid;
  assign symbol_value = res[0].val;
  assign bad_symbol   = res[0].bad;
  assign last         = (cnt == srdenc_pkg::RCNT_W'(1));

endmodule

`default_nettype wire

### sv/srdenc_checker.sv
// ----------------------------------------------------------------------------
// srdenc_checker
// Port-level checks of the descriptor encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srdenc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [srdenc_pkg::SID_W-1:0]    stream_id,
  input wire logic [srdenc_pkg::VAL_W-1:0]    symbol_value,
  input wire logic                            bad_symbol,
  input wire logic                            last
);

  // nothing shown right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled symbol holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stream_id) &&
      $stable(symbol_value) && $stable(bad_symbol) && $stable(last))
    else $error("stalled symbol changed");

  // only character-coded streams may flag a bad symbol, and then with zero value
  a_bad_symbol: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_symbol |-> symbol_value == '0 &&
      (stream_id == srdenc_pkg::S_UREADS || stream_id == srdenc_pkg::S_MMSUBST ||
       stream_id == srdenc_pkg::S_RCOMP))
    else $error("bad symbol on unexpected stream");

  // read type carries one of the three codes
  a_rtype: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_id == srdenc_pkg::S_RTYPE |->
      symbol_value == srdenc_pkg::RTYPE_PERFECT ||
      symbol_value == srdenc_pkg::RTYPE_MISMATCHED ||
      symbol_value == srdenc_pkg::RTYPE_UNALIGNED)
    else $error("unknown read type");

  // mismatch termination flag is a single bit
  a_mmterm: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_id == srdenc_pkg::S_MMTERM |-> symbol_value[srdenc_pkg::VAL_W-1:1] == '0)
    else $error("mismatch terminator out of range");

endmodule

bind single_end_read_descriptor_encoder_core srdenc_checker u_srdenc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .stream_id    (stream_id),
  .symbol_value (symbol_value),
  .bad_symbol   (bad_symbol),
  .last         (last)
);

`default_nettype wire

### bench/tb_single_end_read_descriptor_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_single_end_read_descriptor_encoder_core
// Drives blocks of aligned and unaligned reads, reference bases, mismatches
// and malformed requests into the descriptor encoder with random gaps on
// both sides, predicts every descriptor symbol and compares each one.
// ----------------------------------------------------------------------------

module tb_single_end_read_descriptor_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W        = srdenc_pkg::POS_WIDTH_DEF;
  localparam int LEN_W        = srdenc_pkg::LEN_WIDTH_DEF;
  localparam int ACT_W        = srdenc_pkg::ACT_W;
  localparam int LEN_IN_W     = srdenc_pkg::LEN_IN_W;
  localparam int CNT_W        = srdenc_pkg::CNT_W;
  localparam int CHAR_W       = srdenc_pkg::CHAR_W;
  localparam int SID_W        = srdenc_pkg::SID_W;
  localparam int VAL_W        = srdenc_pkg::VAL_W;
  localparam int RANDOM_ITEMS = 460;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;

  // action code the block ignores
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef struct {
    logic [ACT_W-1:0]    act;
    logic [POS_W-1:0]    rstart;
    logic [POS_W-1:0]    rend;
    logic [LEN_IN_W-1:0] rlen;
    logic [POS_W-1:0]    rpos;
    logic [CHAR_W-1:0]   strand;
    logic [CNT_W-1:0]    mcount;
    logic [CNT_W-1:0]    moff;
    logic [CHAR_W-1:0]   ch;
  } request_t;

  typedef struct {
    logic [SID_W-1:0] sid;
    logic [VAL_W-1:0] val;
    logic             bad;
    logic             lst;
  } symbol_t;

  class descriptor_scoreboard;
    symbol_t          pending_symbols[$];
    logic [POS_W-1:0] prev_pos;
    logic [POS_W-1:0] ref_end_pos;
    logic             first_read;
    logic [LEN_W-1:0] bases_left;
    logic             in_unaligned;
    logic [CNT_W-1:0] mm_left;
    logic             first_mm;
    logic [LEN_W-1:0] held_len;
    int errors;
    int checked;
    int flagged;
    int blocks;
    int aligned_reads;
    int unaligned_reads;

    function new();
      prev_pos     = '0;
      ref_end_pos  = '0;
      first_read   = 1'b1;
      bases_left   = '0;
      in_unaligned = 1'b0;
      mm_left      = '0;
      first_mm     = 1'b1;
      held_len     = '0;
    endfunction

    function void put(logic [SID_W-1:0] sid, logic [VAL_W-1:0] val, logic bad);
      symbol_t s;
      s.sid = sid;
      s.val = val;
      s.bad = bad;
      s.lst = 1'b0;
      pending_symbols = {pending_symbols, s};
    endfunction

    function void put_nucleotide(logic [SID_W-1:0] sid, logic [CHAR_W-1:0] c);
      case (c)
        srdenc_pkg::CH_A: put(sid, VAL_W'(0), 1'b0);
        srdenc_pkg::CH_C: put(sid, VAL_W'(1), 1'b0);
        srdenc_pkg::CH_G: put(sid, VAL_W'(2), 1'b0);
        srdenc_pkg::CH_T: put(sid, VAL_W'(3), 1'b0);
        srdenc_pkg::CH_N: put(sid, VAL_W'(4), 1'b0);
        default:          put(sid, VAL_W'(0), 1'b1);
      endcase
    endfunction

    function void note_request(request_t r);
      logic [POS_W-1:0] delta;
      logic [LEN_W-1:0] len_m1;
      logic [CNT_W-1:0] off;
      int               queued;
      queued = pending_symbols.size();
      len_m1 = r.rlen[LEN_W-1:0] - LEN_W'(1);
      case (r.act)
        srdenc_pkg::ACT_START: begin
          blocks++;
          prev_pos     = '0;
          ref_end_pos  = r.rend;
          first_read   = 1'b1;
          bases_left   = '0;
          in_unaligned = 1'b0;
          mm_left      = '0;
          first_mm     = 1'b1;
          if (r.rstart != r.rend) begin
            delta = r.rend - r.rstart - POS_W'(1);
            put(srdenc_pkg::S_RLEN, VAL_W'(delta), 1'b0);
            put(srdenc_pkg::S_RTYPE, srdenc_pkg::RTYPE_UNALIGNED, 1'b0);
          end
        end
        srdenc_pkg::ACT_ALIGNED: begin
          aligned_reads++;
          bases_left   = '0;
          in_unaligned = 1'b0;
          put(srdenc_pkg::S_RLEN, VAL_W'(len_m1), 1'b0);
          if (r.strand == srdenc_pkg::CH_D) put(srdenc_pkg::S_RCOMP, VAL_W'(0), 1'b0);
          else if (r.strand == srdenc_pkg::CH_R) put(srdenc_pkg::S_RCOMP, VAL_W'(1), 1'b0);
          else put(srdenc_pkg::S_RCOMP, VAL_W'(0), 1'b1);
          delta = first_read ? '0 : r.rpos - prev_pos;
          put(srdenc_pkg::S_POS, VAL_W'(delta), 1'b0);
          prev_pos   = r.rpos;
          first_read = 1'b0;
          put(srdenc_pkg::S_RTYPE, (r.mcount == '0) ? srdenc_pkg::RTYPE_PERFECT
                                                     : srdenc_pkg::RTYPE_MISMATCHED, 1'b0);
          mm_left  = r.mcount;
          first_mm = 1'b1;
          held_len = r.rlen[LEN_W-1:0];
        end
        srdenc_pkg::ACT_MISMATCH: begin
          if (mm_left != '0) begin
            put(srdenc_pkg::S_MMTERM, VAL_W'(0), 1'b0);
            // offsets after the first one of a read are stored minus one
            off = first_mm ? r.moff : r.moff - CNT_W'(1);
            put(srdenc_pkg::S_MMPOS, VAL_W'(off), 1'b0);
            first_mm = 1'b0;
            put(srdenc_pkg::S_MMTYPE, VAL_W'(0), 1'b0);
            put_nucleotide(srdenc_pkg::S_MMSUBST, r.ch);
            mm_left = mm_left - CNT_W'(1);
            if (mm_left == '0) put(srdenc_pkg::S_MMTERM, VAL_W'(1), 1'b0);
          end
        end
        srdenc_pkg::ACT_UNALIGNED: begin
          unaligned_reads++;
          mm_left    = '0;
          first_read = 1'b0;
          put(srdenc_pkg::S_RTYPE, srdenc_pkg::RTYPE_UNALIGNED, 1'b0);
          put(srdenc_pkg::S_RLEN, VAL_W'(len_m1), 1'b0);
          held_len     = r.rlen[LEN_W-1:0];
          bases_left   = r.rlen[LEN_W-1:0];
          in_unaligned = (r.rlen[LEN_W-1:0] != '0);
        end
        srdenc_pkg::ACT_BASE: begin
          put_nucleotide(srdenc_pkg::S_UREADS, r.ch);
          if (in_unaligned && bases_left != '0) begin
            bases_left = bases_left - LEN_W'(1);
            if (bases_left == '0) begin
              // pseudo-alignment of the finished unaligned read
              in_unaligned = 1'b0;
              delta = ref_end_pos - prev_pos;
              put(srdenc_pkg::S_POS, VAL_W'(delta), 1'b0);
              put(srdenc_pkg::S_RCOMP, VAL_W'(0), 1'b0);
              len_m1 = held_len - LEN_W'(1);
              put(srdenc_pkg::S_RLEN, VAL_W'(len_m1), 1'b0);
              put(srdenc_pkg::S_RTYPE, srdenc_pkg::RTYPE_PERFECT, 1'b0);
              prev_pos    = ref_end_pos;
              ref_end_pos = ref_end_pos + POS_W'(held_len);
            end
          end
        end
        default: ;
      endcase
      if (pending_symbols.size() > queued)
        pending_symbols[pending_symbols.size() - 1].lst = 1'b1;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_symbol(logic [SID_W-1:0] sid, logic [VAL_W-1:0] val, logic bad, logic lst);
      symbol_t e;
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("symbol with nothing expected, stream %0d value 0x%0h",
                                  sid, val));
        return;
      end
      e = pending_symbols.pop_front();
      checked++;
      if (sid !== e.sid)
        report_mismatch($sformatf("stream_id %0d, expected %0d", sid, e.sid));
      if (val !== e.val)
        report_mismatch($sformatf("symbol_value 0x%0h, expected 0x%0h (stream %0d)",
                                  val, e.val, e.sid));
      if (bad !== e.bad)
        report_mismatch($sformatf("bad_symbol %b, expected %b (stream %0d)", bad, e.bad, e.sid));
      if (lst !== e.lst)
        report_mismatch($sformatf("last %b, expected %b (stream %0d)", lst, e.lst, e.sid));
      if (bad === 1'b1 && e.bad) flagged++;
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [ACT_W-1:0]    action;
  logic [POS_W-1:0]    ref_start;
  logic [POS_W-1:0]    ref_end;
  logic [LEN_IN_W-1:0] read_len;
  logic [POS_W-1:0]    read_position;
  logic [CHAR_W-1:0]   strand_char;
  logic [CNT_W-1:0]    mismatch_count;
  logic [CNT_W-1:0]    mismatch_offset;
  logic [CHAR_W-1:0]   base_char;
  logic                out_valid;
  logic                out_ready;
  logic [SID_W-1:0]    stream_id;
  logic [VAL_W-1:0]    symbol_value;
  logic                bad_symbol;
  logic                last;

  descriptor_scoreboard sb;
  int sent;
  int in_gap_max  = 17;
  int out_stall_max = 17;
  int cycles = 0;

  single_end_read_descriptor_encoder_core #(
    .POS_WIDTH(POS_W),
    .LEN_WIDTH(LEN_W)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .ref_start       (ref_start),
    .ref_end         (ref_end),
    .read_len        (read_len),
    .read_position   (read_position),
    .strand_char     (strand_char),
    .mismatch_count  (mismatch_count),
    .mismatch_offset (mismatch_offset),
    .base_char       (base_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .stream_id       (stream_id),
    .symbol_value    (symbol_value),
    .bad_symbol      (bad_symbol),
    .last            (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_single_end_read_descriptor_encoder_core: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_symbol(stream_id, symbol_value, bad_symbol, last);
  end

  // result side: random stall before each symbol
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[POS_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] pick_base();
    if ($urandom_range(0, 11) == 0) return CHAR_W'($urandom());
    case ($urandom_range(0, 4))
      0:       return srdenc_pkg::CH_A;
      1:       return srdenc_pkg::CH_C;
      2:       return srdenc_pkg::CH_G;
      3:       return srdenc_pkg::CH_T;
      default: return srdenc_pkg::CH_N;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_strand();
    if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom());
    return ($urandom_range(0, 1) != 0) ? srdenc_pkg::CH_R : srdenc_pkg::CH_D;
  endfunction

  // unused fields carry random junk
  function automatic request_t random_request();
    request_t r;
    r.act    = ACT_W'($urandom_range(0, 7));
    r.rstart = rand_pos();
    r.rend   = rand_pos();
    r.rlen   = LEN_IN_W'($urandom());
    r.rpos   = rand_pos();
    r.strand = CHAR_W'($urandom());
    r.mcount = CNT_W'($urandom());
    r.moff   = CNT_W'($urandom());
    r.ch     = CHAR_W'($urandom());
    return r;
  endfunction

  task automatic push_request(request_t r);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= r.act;
    ref_start       <= r.rstart;
    ref_end         <= r.rend;
    read_len        <= r.rlen;
    read_position   <= r.rpos;
    strand_char     <= r.strand;
    mismatch_count  <= r.mcount;
    mismatch_offset <= r.moff;
    base_char       <= r.ch;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    if (r.act <= srdenc_pkg::ACT_BASE) sent++;
  endtask

  task automatic send_start(logic [POS_W-1:0] s, logic [POS_W-1:0] e);
    request_t r;
    r = random_request();
    r.act    = srdenc_pkg::ACT_START;
    r.rstart = s;
    r.rend   = e;
    push_request(r);
  endtask

  task automatic send_base(logic [CHAR_W-1:0] c);
    request_t r;
    r = random_request();
    r.act = srdenc_pkg::ACT_BASE;
    r.ch  = c;
    push_request(r);
  endtask

  task automatic send_aligned(logic [POS_W-1:0] p, logic [LEN_IN_W-1:0] len,
                              logic [CHAR_W-1:0] strand, logic [CNT_W-1:0] count);
    request_t r;
    r = random_request();
    r.act    = srdenc_pkg::ACT_ALIGNED;
    r.rpos   = p;
    r.rlen   = len;
    r.strand = strand;
    r.mcount = count;
    push_request(r);
  endtask

  task automatic send_mismatch(logic [CNT_W-1:0] off, logic [CHAR_W-1:0] c);
    request_t r;
    r = random_request();
    r.act  = srdenc_pkg::ACT_MISMATCH;
    r.moff = off;
    r.ch   = c;
    push_request(r);
  endtask

  task automatic send_unaligned(logic [LEN_IN_W-1:0] len);
    request_t r;
    r = random_request();
    r.act  = srdenc_pkg::ACT_UNALIGNED;
    r.rlen = len;
    push_request(r);
  endtask

  task automatic run_directed();
    request_t r;
    send_start('0, '0);                 // empty span
    send_start(POS_MAX, '0);
    send_start('0, POS_MAX);
    send_base(srdenc_pkg::CH_A);
    send_base(srdenc_pkg::CH_C);
    send_base(srdenc_pkg::CH_G);
    send_base(srdenc_pkg::CH_T);
    send_base(srdenc_pkg::CH_N);
    send_base(8'h00);
    send_mismatch(16'h1234, srdenc_pkg::CH_A);      // nothing pending
    send_aligned(POS_MAX, 16'd1, srdenc_pkg::CH_D, 16'd0);
    send_aligned('0, 16'd0, srdenc_pkg::CH_R, 16'd2);
    send_mismatch(16'hFFFF, srdenc_pkg::CH_T);
    send_mismatch(16'd0, 8'hFF);        // zero offset after the first wraps
    send_aligned(POS_W'(5), 16'hFFFF, 8'h00, 16'hFFFF);
    send_mismatch(16'd7, srdenc_pkg::CH_G);
    send_unaligned(16'd0);              // zero-length unaligned read
    send_base(srdenc_pkg::CH_C);
    send_unaligned(16'd2);              // reference end wraps past the top
    send_base(srdenc_pkg::CH_N);
    send_base(8'h80);
    send_unaligned(16'd3);
    send_base(srdenc_pkg::CH_A);
    send_aligned(POS_W'(9), 16'd4, srdenc_pkg::CH_D, 16'd1);
    r = random_request();
    r.act = ACT_SPARE_HI;
    push_request(r);
  endtask

  task automatic random_block();
    logic [POS_W-1:0]    s;
    logic [POS_W-1:0]    e;
    logic [POS_W-1:0]    p;
    logic [LEN_IN_W-1:0] len;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    off;
    int                  nsend;
    int                  kind;
    request_t            r;
    in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 17;
    out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
    s = rand_pos();
    kind = $urandom_range(0, 7);
    if (kind == 0) e = s;
    else if (kind == 1) begin
      s = POS_MAX - POS_W'($urandom_range(0, 20));
      e = s + POS_W'($urandom_range(1, 40));
    end else if (kind == 2) e = rand_pos();
    else e = s + POS_W'($urandom_range(1, 100000));
    send_start(s, e);
    repeat ($urandom_range(0, 5)) send_base(pick_base());
    p = s;
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        p = ($urandom_range(0, 9) == 0) ? rand_pos() : p + POS_W'($urandom_range(0, 500));
        len = ($urandom_range(0, 15) == 0) ? LEN_IN_W'($urandom())
                                           : LEN_IN_W'($urandom_range(1, 150));
        count = ($urandom_range(0, 9) < 4) ? '0 : CNT_W'($urandom_range(1, 3));
        send_aligned(p, len, pick_strand(), count);
        // broken reads: some mismatches missing or one too many
        nsend = int'(count);
        if ($urandom_range(0, 9) == 0) nsend = $urandom_range(0, int'(count) + 1);
        repeat (nsend) begin
          if ($urandom_range(0, 9) == 0) off = CNT_W'($urandom());
          else off = CNT_W'($urandom_range(0, (len == '0) ? 0 : int'(len) - 1));
          send_mismatch(off, pick_base());
        end
      end else if (kind < 9) begin
        if ($urandom_range(0, 19) == 0) len = '0;
        else if ($urandom_range(0, 29) == 0) len = LEN_IN_W'($urandom_range(20, 60));
        else len = LEN_IN_W'($urandom_range(1, 8));
        send_unaligned(len);
        nsend = int'(len);
        if ($urandom_range(0, 9) == 0) nsend = $urandom_range(0, int'(len));
        repeat (nsend) send_base(pick_base());
      end else begin
        r = random_request();
        push_request(r);
      end
    end
  endtask

  initial begin
    int first_random;
    sb = new();
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    action          <= srdenc_pkg::ACT_START;
    ref_start       <= '0;
    ref_end         <= '0;
    read_len        <= '0;
    read_position   <= '0;
    strand_char     <= '0;
    mismatch_count  <= '0;
    mismatch_offset <= '0;
    base_char       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    first_random = sent;
    while (sent < first_random + RANDOM_ITEMS) random_block();
    in_valid <= 1'b0;
    while (sb.pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests over %0d blocks (%0d aligned, %0d unaligned reads)",
             sent, sb.blocks, sb.aligned_reads, sb.unaligned_reads);
    $display("%0d descriptor symbols compared, %0d with a bad character flag",
             sb.checked, sb.flagged);
    if (sb.errors == 0)
      $display("tb_single_end_read_descriptor_encoder_core: clean");
    else
      $display("tb_single_end_read_descriptor_encoder_core: errors");
    $finish;
  end

endmodule

### filelist.f
sv/srdenc_pkg.sv
sv/single_end_read_descriptor_encoder_core.sv
sv/srdenc_checker.sv
bench/tb_single_end_read_descriptor_encoder_core.sv
